// ===== src/plte_pkg.sv =====
// Shared widths, register indexes and pipeline stage types for the palette light table entry.
`timescale 1ns / 1ps
package plte_pkg;

  localparam int CountW  = 6;   // width of the level count registers
  localparam int LevelW  = 6;   // width of a table row
  localparam int CompW   = 8;   // width of one palette component
  localparam int NumW    = 14;  // component times row, up to 255 * 63
  localparam int QuoW    = 8;   // every quotient stays below 256
  localparam int Lanes   = 4;   // low, green, high and the white fade
  localparam int CfgAddrW = 2;
  localparam int CountMax = (1 << CountW) - 1;

  localparam logic [CfgAddrW-1:0] CfgDark   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgBright = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgFormat = 2'd2;

  // pixel_format bits
  localparam int Fmt565Bit  = 0;
  localparam int FmtBlueBit = 1;

  localparam int LaneLo    = 0;
  localparam int LaneGreen = 1;
  localparam int LaneHi    = 2;
  localparam int LaneWhite = 3;

  typedef struct packed {
    logic                    valid;
    logic                    invalid;
    logic                    is565;
    logic [Lanes-2:0][CompW-1:0] comp;   // low, green, high
    logic [LevelW-1:0]       mult;       // row for dark, kept share for bright
    logic [LevelW-1:0]       white_mult; // k + 1 for bright rows, else 0
    logic [CountW-1:0]       divisor;
  } front_t;

  typedef struct packed {
    logic                       valid;
    logic                       invalid;
    logic                       is565;
    logic [CountW-1:0]          divisor;
    logic [Lanes-1:0][NumW-1:0] rem;
    logic [Lanes-1:0][QuoW-1:0] quo;
  } div_stage_t;

endpackage

// ===== src/palette_light_table_entry.sv =====
// Top level: pipelined light table entry with per-lane restoring dividers.
`timescale 1ns / 1ps
// Takes one request per cycle while in_ready_o is high and returns one lit pixel per request,
// in order. The stages are: level decode and operand select, the component multiply, eight
// divider stages that each resolve one quotient bit for all four lanes at once (three
// components and the white fade, sharing one divisor), and the pack into the output register.
// The whole pipeline advances as one: it holds while a finished pixel waits at the output, so
// in_ready_o follows out_ready_i whenever the output register is full. Configuration takes
// effect for requests accepted after the write.
module palette_light_table_entry #(
  parameter int MAX_DARK_LEVELS   = 32,
  parameter int MAX_BRIGHT_LEVELS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [plte_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [plte_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [plte_pkg::LevelW-1:0]   light_level_i,
  input  logic [plte_pkg::CompW-1:0]    pal_red_i,
  input  logic [plte_pkg::CompW-1:0]    pal_green_i,
  input  logic [plte_pkg::CompW-1:0]    pal_blue_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   lit_pixel_o,
  output logic                          level_invalid_o
);

  localparam int CountW = plte_pkg::CountW;
  localparam int LevelW = plte_pkg::LevelW;
  localparam int CompW  = plte_pkg::CompW;
  localparam int NumW   = plte_pkg::NumW;
  localparam int QuoW   = plte_pkg::QuoW;
  localparam int Lanes  = plte_pkg::Lanes;
  localparam int DarkCap =
    (MAX_DARK_LEVELS > plte_pkg::CountMax) ? plte_pkg::CountMax : MAX_DARK_LEVELS;
  localparam int BrightCap =
    (MAX_BRIGHT_LEVELS > plte_pkg::CountMax) ? plte_pkg::CountMax : MAX_BRIGHT_LEVELS;

  logic [CountW-1:0] dark_q, bright_q;
  logic [1:0]        fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q   <= CountW'(16);
      bright_q <= CountW'(16);
      fmt_q    <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        plte_pkg::CfgDark:   dark_q   <= cfg_wdata_i;
        plte_pkg::CfgBright: bright_q <= cfg_wdata_i;
        plte_pkg::CfgFormat: fmt_q    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  logic advance;
  logic out_valid_q;
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // ---- stage 0: decode the row and pick operands
  logic [CountW-1:0] dark_eff, bright_eff, keep;
  logic [LevelW-1:0] k;
  logic [CountW:0]   total;
  logic              is_dark, invalid;
  plte_pkg::front_t  front_d, front_q;

  always_comb begin
    dark_eff   = (dark_q > CountW'(DarkCap)) ? CountW'(DarkCap) : dark_q;
    bright_eff = (bright_q > CountW'(BrightCap)) ? CountW'(BrightCap) : bright_q;
    total      = {1'b0, dark_eff} + {1'b0, bright_eff};
    invalid    = {1'b0, light_level_i} >= total;
    is_dark    = light_level_i < dark_eff;
    k          = light_level_i - dark_eff;
    keep       = bright_eff - CountW'(1) - k;

    front_d.valid   = in_valid_i;
    front_d.invalid = invalid;
    front_d.is565   = fmt_q[plte_pkg::Fmt565Bit];
    front_d.comp[plte_pkg::LaneLo]    = fmt_q[plte_pkg::FmtBlueBit] ? pal_blue_i : pal_red_i;
    front_d.comp[plte_pkg::LaneGreen] = pal_green_i;
    front_d.comp[plte_pkg::LaneHi]    = fmt_q[plte_pkg::FmtBlueBit] ? pal_red_i : pal_blue_i;
    // keep the divider well defined for out-of-range rows and a single dark row
    priority if (invalid) begin
      front_d.mult       = '0;
      front_d.white_mult = '0;
      front_d.divisor    = CountW'(1);
    end else if (is_dark) begin
      front_d.mult       = light_level_i;
      front_d.white_mult = '0;
      front_d.divisor    = (dark_eff < CountW'(2)) ? CountW'(1) : dark_eff - CountW'(1);
    end else begin
      front_d.mult       = keep;
      front_d.white_mult = k + LevelW'(1);
      front_d.divisor    = bright_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else if (advance) begin
      front_q <= front_d;
    end
  end

  // ---- stage 1: numerators
  plte_pkg::div_stage_t div_d [QuoW+1];
  plte_pkg::div_stage_t div_q [QuoW+1];

  always_comb begin
    div_d[0].valid   = front_q.valid;
    div_d[0].invalid = front_q.invalid;
    div_d[0].is565   = front_q.is565;
    div_d[0].divisor = front_q.divisor;
    div_d[0].quo     = '0;
    for (int l = 0; l < Lanes - 1; l++) begin
      div_d[0].rem[l] = NumW'(front_q.comp[l]) * NumW'(front_q.mult);
    end
    div_d[0].rem[plte_pkg::LaneWhite] = NumW'(front_q.white_mult) * NumW'(8'hff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q[0] <= '0;
    end else if (advance) begin
      div_q[0] <= div_d[0];
    end
  end

  // ---- divider stages: one quotient bit per stage, most significant first
  for (genvar g = 0; g < QuoW; g++) begin : gen_div
    localparam int Bit = QuoW - 1 - g;
    logic [NumW-1:0] trial;

    always_comb begin
      trial = NumW'(div_q[g].divisor) << Bit;
      div_d[g+1] = div_q[g];
      for (int l = 0; l < Lanes; l++) begin
        if (div_q[g].rem[l] >= trial) begin
          div_d[g+1].rem[l]      = div_q[g].rem[l] - trial;
          div_d[g+1].quo[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[g+1] <= '0;
      end else if (advance) begin
        div_q[g+1] <= div_d[g+1];
      end
    end
  end

  // ---- output stage: add the white fade and pack
  plte_pkg::div_stage_t last;
  logic [Lanes-2:0][CompW-1:0] lit;
  logic [15:0] pix_d, pix_q;
  logic        inv_q;

  always_comb begin
    last = div_q[QuoW];
    for (int l = 0; l < Lanes - 1; l++) begin
      lit[l] = last.quo[l] + last.quo[plte_pkg::LaneWhite];
    end
    if (last.invalid) begin
      pix_d = '0;
    end else if (last.is565) begin
      pix_d = {lit[plte_pkg::LaneHi][7:3], lit[plte_pkg::LaneGreen][7:2],
               lit[plte_pkg::LaneLo][7:3]};
    end else begin
      pix_d = {1'b0, lit[plte_pkg::LaneHi][7:3], lit[plte_pkg::LaneGreen][7:3],
               lit[plte_pkg::LaneLo][7:3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pix_q <= pix_d;
      inv_q <= last.invalid;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lit_pixel_o     = pix_q;
  assign level_invalid_o = inv_q;

endmodule

// ===== src/plte_checker.sv =====
// Port-level assertions for the palette light table entry, bound to the top level.
`timescale 1ns / 1ps
module plte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] lit_pixel_o,
  input logic        level_invalid_o
);

  // a waiting result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lit_pixel_o)
      && $stable(level_invalid_o))
    else $error("stalled result changed");

  // the pipeline takes a request exactly when the output slot frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");

  // an out-of-range row gives a blank pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && level_invalid_o |-> lit_pixel_o == 16'h0000)
    else $error("invalid level with nonzero pixel");

  // leave reset with no result pending
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result pending after reset");

endmodule

bind palette_light_table_entry plte_checker u_plte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .lit_pixel_o     (lit_pixel_o),
  .level_invalid_o (level_invalid_o)
);
